// ===== rtl/lsfe_pkg.sv =====
// lsfe_pkg: shared types and codes of the lsb stego frame extractor
// used by every module of the block; no dependencies

package lsfe_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_HEADER_BYTES   = 2'd0;
  localparam logic [1:0] REG_EXPECTED_MAGIC = 2'd1;
  localparam logic [1:0] REG_MAGIC_LENGTH   = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0]  HEADER_BYTES_RESET   = 8'd54;
  localparam logic [63:0] EXPECTED_MAGIC_RESET = 64'd0;
  localparam logic [3:0]  MAGIC_LENGTH_RESET   = 4'd2;

  // result kinds
  localparam logic [1:0] KIND_EXT    = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_MLEN  = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH  = 2'd2;
  localparam logic [1:0] STATUS_BAD_XLEN  = 2'd3;

  // depth of the bit queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

  // configuration registers as one group
  typedef struct packed {
    logic [7:0]  header_bytes;
    logic [63:0] expected_magic;
    logic [3:0]  magic_length;
  } cfg_t;

  // one payload bit; first marks the first bit after a restart
  typedef struct packed {
    logic first;
    logic bit_val;
  } token_t;

  // parse phases of the back end
  typedef enum logic [6:0] {
    PH_MLEN   = 7'b0000001,
    PH_MAGIC  = 7'b0000010,
    PH_XLEN   = 7'b0000100,
    PH_XBYTES = 7'b0001000,
    PH_DLEN   = 7'b0010000,
    PH_DATA   = 7'b0100000,
    PH_DONE   = 7'b1000000
  } phase_t;

endpackage

// ===== rtl/lsfe_front.sv =====
// lsfe_front: accepts image bytes, skips the header, emits payload bit tokens
// depends on lsfe_pkg

module lsfe_front import lsfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pixel_byte,
  input  logic       start_of_image,
  input  logic       queue_full,
  output logic       push,
  output token_t     token
);

  logic       in_header;
  logic [7:0] header_count;
  logic       in_header_next;
  logic [7:0] header_count_next;
  logic       accept;
  logic       hdr;
  logic [7:0] cnt;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hdr               = start_of_image ? 1'b1 : in_header;
    cnt               = start_of_image ? 8'd0 : header_count;
    in_header_next    = hdr;
    header_count_next = cnt;
    push              = 1'b0;
    token.first       = 1'b0;
    token.bit_val     = pixel_byte[0];
    if (hdr && (cnt < cfg.header_bytes)) begin
      header_count_next = cnt + 8'd1;
    end else if (hdr) begin
      in_header_next = 1'b0;
      push           = accept;
      token.first    = 1'b1;
    end else begin
      push = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_header    <= 1'b1;
      header_count <= 8'd0;
    end else if (accept) begin
      in_header    <= in_header_next;
      header_count <= header_count_next;
    end
  end

endmodule

// ===== rtl/lsfe_queue.sv =====
// lsfe_queue: short fifo of bit tokens between front and back
// depends on lsfe_pkg

module lsfe_queue import lsfe_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_token,
  input  logic   pop,
  output token_t pop_token,
  output logic   full,
  output logic   not_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  token_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_token = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/lsfe_back.sv =====
// lsfe_back: collects payload bits, parses the frame and holds the result word
// depends on lsfe_pkg

module lsfe_back import lsfe_pkg::*; #(
  parameter int LENGTH_BITS     = 32,
  parameter int MAGIC_MAX_BYTES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       token_valid,
  input  token_t     token,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [1:0] status,
  output logic       last
);

  localparam int CNT_W = $clog2(LENGTH_BITS);
  localparam int REM_W = LENGTH_BITS - 1;
  localparam int POS_W = (MAGIC_MAX_BYTES > 1) ? $clog2(MAGIC_MAX_BYTES) : 1;
  localparam logic [3:0] MAGIC_MAX = 4'(MAGIC_MAX_BYTES);

  phase_t                 phase, phase_next, ph;
  logic [CNT_W-1:0]       bit_count, bit_count_next, cnt;
  logic [LENGTH_BITS-1:0] bit_shift, bit_shift_next, sh, sh_new;
  logic [REM_W-1:0]       remaining, remaining_next, rem;
  logic [POS_W-1:0]       magic_pos, magic_pos_next, mpos;
  logic                   magic_differs, magic_differs_next, mdiff;

  logic       is_len;
  logic       field_done;
  logic       neg;
  logic [3:0] eff_len;
  logic [7:0] expect_byte;
  logic       res;
  logic [7:0] res_byte;
  logic [1:0] res_kind;
  logic [1:0] res_status;
  logic       res_last;

  assign pop     = token_valid && (!out_valid || out_ready);
  assign eff_len = (cfg.magic_length > MAGIC_MAX) ? MAGIC_MAX : cfg.magic_length;

  always_comb begin
    // a restart token parses from a fresh frame
    ph    = token.first ? PH_MLEN : phase;
    cnt   = token.first ? '0 : bit_count;
    sh    = token.first ? '0 : bit_shift;
    rem   = token.first ? '0 : remaining;
    mpos  = token.first ? '0 : magic_pos;
    mdiff = token.first ? 1'b0 : magic_differs;

    is_len      = (ph == PH_MLEN) || (ph == PH_XLEN) || (ph == PH_DLEN);
    sh_new      = {sh[LENGTH_BITS-2:0], token.bit_val};
    field_done  = is_len ? (cnt == CNT_W'(LENGTH_BITS - 1)) : (cnt == CNT_W'(7));
    neg         = sh_new[LENGTH_BITS-1];
    expect_byte = cfg.expected_magic[8*mpos +: 8];

    phase_next         = ph;
    bit_count_next     = cnt;
    bit_shift_next     = sh;
    remaining_next     = rem;
    magic_pos_next     = mpos;
    magic_differs_next = mdiff;
    res        = 1'b0;
    res_byte   = 8'd0;
    res_kind   = KIND_STATUS;
    res_status = STATUS_OK;
    res_last   = 1'b0;

    if (ph != PH_DONE) begin
      if (!field_done) begin
        bit_count_next = cnt + CNT_W'(1);
        bit_shift_next = sh_new;
      end else begin
        bit_count_next = '0;
        bit_shift_next = '0;
        case (ph)
          PH_MLEN: begin
            if (neg) begin
              phase_next = PH_DONE;
              res        = 1'b1;
              res_status = STATUS_BAD_MLEN;
              res_last   = 1'b1;
            end else if (sh_new != LENGTH_BITS'(eff_len)) begin
              phase_next = PH_DONE;
              res        = 1'b1;
              res_status = STATUS_MISMATCH;
              res_last   = 1'b1;
            end else begin
              remaining_next     = sh_new[REM_W-1:0];
              magic_pos_next     = '0;
              magic_differs_next = 1'b0;
              phase_next         = (eff_len == 4'd0) ? PH_XLEN : PH_MAGIC;
            end
          end
          PH_MAGIC: begin
            magic_differs_next = mdiff || (sh_new[7:0] != expect_byte);
            magic_pos_next     = mpos + POS_W'(1);
            remaining_next     = rem - REM_W'(1);
            if (rem == REM_W'(1)) begin
              if (magic_differs_next) begin
                phase_next = PH_DONE;
                res        = 1'b1;
                res_status = STATUS_MISMATCH;
                res_last   = 1'b1;
              end else begin
                phase_next = PH_XLEN;
              end
            end
          end
          PH_XLEN: begin
            if (neg || (sh_new == '0)) begin
              phase_next = PH_DONE;
              res        = 1'b1;
              res_status = STATUS_BAD_XLEN;
              res_last   = 1'b1;
            end else begin
              remaining_next = sh_new[REM_W-1:0];
              phase_next     = PH_XBYTES;
            end
          end
          PH_XBYTES: begin
            remaining_next = rem - REM_W'(1);
            if (rem == REM_W'(1)) begin
              phase_next = PH_DLEN;
            end
            res      = 1'b1;
            res_byte = sh_new[7:0];
            res_kind = KIND_EXT;
          end
          PH_DLEN: begin
            // negative data length counts as empty
            if (neg || (sh_new == '0)) begin
              phase_next = PH_DONE;
              res        = 1'b1;
              res_last   = 1'b1;
            end else begin
              remaining_next = sh_new[REM_W-1:0];
              phase_next     = PH_DATA;
            end
          end
          PH_DATA: begin
            remaining_next = rem - REM_W'(1);
            res      = 1'b1;
            res_byte = sh_new[7:0];
            res_kind = KIND_DATA;
            if (rem == REM_W'(1)) begin
              phase_next = PH_DONE;
              res_last   = 1'b1;
            end
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MLEN;
      bit_count     <= '0;
      bit_shift     <= '0;
      remaining     <= '0;
      magic_pos     <= '0;
      magic_differs <= 1'b0;
    end else if (pop) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      bit_shift     <= bit_shift_next;
      remaining     <= remaining_next;
      magic_pos     <= magic_pos_next;
      magic_differs <= magic_differs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res) begin
      out_byte <= res_byte;
      kind     <= res_kind;
      status   <= res_status;
      last     <= res_last;
    end
  end

endmodule

// ===== rtl/lsb_stego_frame_extractor_core.sv =====
// lsb_stego_frame_extractor_core: top level of the lsb stego frame extractor
// depends on lsfe_pkg, lsfe_front, lsfe_queue and lsfe_back

// Takes one image byte per cycle on the input channel while the bit queue
// has room and returns extension and data bytes of the hidden frame, plus
// one status word when the frame fails or ends empty. The sustained rate is
// one byte per cycle while the output does not stall: the front end drops
// header bytes and passes each payload bit as a word into a four-deep queue,
// and the back end folds one bit per cycle into the field shift register and
// the parse state while no result waits, so every byte finishes in one pass.
// A byte that completes an extension or data byte enters the queue register
// when accepted and the output register when the back end pops it, which an
// output stall can delay. The output register frees the input side from
// output stalls until the queue fills. Configuration writes go straight into
// the registers and must only happen while no word is in flight.

module lsb_stego_frame_extractor_core import lsfe_pkg::*; #(
  parameter int LENGTH_BITS     = 32,
  parameter int MAGIC_MAX_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data,
  // image byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel_byte,
  input  logic        start_of_image,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic        last
);

  cfg_t   cfg;
  logic   push;
  token_t push_token;
  logic   pop;
  token_t pop_token;
  logic   queue_full;
  logic   queue_not_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_bytes   <= HEADER_BYTES_RESET;
      cfg.expected_magic <= EXPECTED_MAGIC_RESET;
      cfg.magic_length   <= MAGIC_LENGTH_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_HEADER_BYTES:   cfg.header_bytes   <= wr_data[7:0];
        REG_EXPECTED_MAGIC: cfg.expected_magic <= wr_data;
        REG_MAGIC_LENGTH:   cfg.magic_length   <= wr_data[3:0];
        default:            ;
      endcase
    end
  end

  // front: header skip and bit extraction
  lsfe_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_byte     (pixel_byte),
    .start_of_image (start_of_image),
    .queue_full     (queue_full),
    .push           (push),
    .token          (push_token)
  );

  // queue of payload bits
  lsfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .pop_token  (pop_token),
    .full       (queue_full),
    .not_empty  (queue_not_empty)
  );

  // back: frame parse and result register
  lsfe_back #(
    .LENGTH_BITS     (LENGTH_BITS),
    .MAGIC_MAX_BYTES (MAGIC_MAX_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .token_valid (queue_not_empty),
    .token       (pop_token),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .status      (status),
    .last        (last)
  );

  // status-only words carry no byte and always close the frame
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_STATUS) |-> (out_byte == 8'd0) && last)
    else $error("status word with byte or without last");

  // extension bytes never close the frame and never carry an error
  a_ext_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_EXT) |-> !last && (status == STATUS_OK))
    else $error("extension word with last or error status");

  // an error code only comes with a status-only word
  a_error_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> (kind == KIND_STATUS))
    else $error("error status on a byte word");

  // the back end never drains an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> queue_not_empty)
    else $error("pop from empty queue");

endmodule

// ===== dv/lsfe_frame_checker.sv =====
// lsfe_frame_checker: watches the image and result channels of the lsb stego
// frame extractor, predicts every result word and compares it
// depends on lsfe_pkg for register indexes, result kinds and status codes

module lsfe_frame_checker import lsfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [63:0] wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  pixel_byte,
  input  logic        start_of_image,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic [1:0]  kind,
  input  logic [1:0]  status,
  input  logic        last,
  input  logic        flush,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ST_HEADER, ST_MLEN, ST_MAGIC, ST_XLEN, ST_XBYTES, ST_DLEN, ST_DATA, ST_DONE
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } frame_word_t;

  // shadow registers and parse state
  cfg_t         regs;
  parse_state_t ph;
  logic [7:0]   hdr_seen;
  logic [4:0]   nbits;
  logic [31:0]  shreg;
  logic [31:0]  left;
  logic [3:0]   mpos;
  logic         mbad;

  frame_word_t  awaited[$];
  frame_word_t  got, want;
  logic         hit;
  int           mismatches = 0;
  int           checked = 0;
  bit           flushed = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic frame_word_t status_word(input logic [1:0] code);
    return '{data_byte: 8'd0, kind: KIND_STATUS, status: code, last: 1'b1};
  endfunction

  task automatic restart_parse();
    ph = ST_HEADER;
    hdr_seen = '0;
    nbits = '0;
    shreg = '0;
    left = '0;
    mpos = '0;
    mbad = 1'b0;
  endtask

  // one image word through the parser; at most one result word
  task automatic extract_step(input logic [7:0] px, input logic sof,
                              output logic produced, output frame_word_t w);
    int          need;
    logic [31:0] val;
    logic        neg;
    logic [3:0]  span;
    logic [7:0]  ref_char;
    produced = 1'b0;
    w = '0;
    if (sof) restart_parse();
    if (ph == ST_DONE) return;
    if (ph == ST_HEADER) begin
      if (hdr_seen < regs.header_bytes) begin
        hdr_seen++;
        return;
      end
      ph = ST_MLEN;
      nbits = '0;
      shreg = '0;
    end
    need = (ph == ST_MLEN || ph == ST_XLEN || ph == ST_DLEN) ? 32 : 8;
    shreg = {shreg[30:0], px[0]};
    if (nbits + 1 < need) begin
      nbits++;
      return;
    end
    nbits = '0;
    val = (need == 8) ? {24'd0, shreg[7:0]} : shreg;
    shreg = '0;
    neg = (need != 8) && val[31];
    span = (regs.magic_length > 4'd8) ? 4'd8 : regs.magic_length;
    case (ph)
      ST_MLEN: begin
        if (neg) begin
          ph = ST_DONE;
          produced = 1'b1;
          w = status_word(STATUS_BAD_MLEN);
        end else if (val != span) begin
          ph = ST_DONE;
          produced = 1'b1;
          w = status_word(STATUS_MISMATCH);
        end else begin
          left = val;
          mpos = '0;
          mbad = 1'b0;
          ph = (val == 0) ? ST_XLEN : ST_MAGIC;
        end
      end
      ST_MAGIC: begin
        ref_char = regs.expected_magic[8 * mpos[2:0] +: 8];
        if (val[7:0] != ref_char) mbad = 1'b1;
        mpos++;
        left--;
        if (left == 0) begin
          if (mbad) begin
            ph = ST_DONE;
            produced = 1'b1;
            w = status_word(STATUS_MISMATCH);
          end else begin
            ph = ST_XLEN;
          end
        end
      end
      ST_XLEN: begin
        if (neg || val == 0) begin
          ph = ST_DONE;
          produced = 1'b1;
          w = status_word(STATUS_BAD_XLEN);
        end else begin
          left = val;
          ph = ST_XBYTES;
        end
      end
      ST_XBYTES: begin
        left--;
        if (left == 0) ph = ST_DLEN;
        produced = 1'b1;
        w = '{data_byte: val[7:0], kind: KIND_EXT, status: STATUS_OK, last: 1'b0};
      end
      ST_DLEN: begin
        // negative data length counts as empty
        if (neg || val == 0) begin
          ph = ST_DONE;
          produced = 1'b1;
          w = status_word(STATUS_OK);
        end else begin
          left = val;
          ph = ST_DATA;
        end
      end
      ST_DATA: begin
        left--;
        produced = 1'b1;
        w = '{data_byte: val[7:0], kind: KIND_DATA, status: STATUS_OK, last: left == 0};
        if (left == 0) ph = ST_DONE;
      end
      default: ph = ST_DONE;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      regs = '{header_bytes: HEADER_BYTES_RESET, expected_magic: EXPECTED_MAGIC_RESET,
               magic_length: MAGIC_LENGTH_RESET};
      awaited.delete();
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_HEADER_BYTES:   regs.header_bytes = wr_data[7:0];
          REG_EXPECTED_MAGIC: regs.expected_magic = wr_data;
          REG_MAGIC_LENGTH:   regs.magic_length = wr_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_byte, kind, status, last};
        checked++;
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", got));
        end else begin
          want = awaited.pop_front();
          if (got.data_byte !== want.data_byte)
            report_mismatch($sformatf("out_byte %h, want %h", got.data_byte, want.data_byte));
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
      end
      if (in_valid && in_ready) begin
        extract_step(pixel_byte, start_of_image, hit, want);
        if (hit) awaited.push_back(want);
      end
      if (flush && !flushed) begin
        flushed = 1'b1;
        if (awaited.size() != 0)
          report_mismatch($sformatf("%0d result words never arrived", awaited.size()));
      end
    end
    fail_count   <= mismatches;
    pending      <= awaited.size();
    results_seen <= checked;
  end

endmodule

// ===== dv/lsb_stego_frame_extractor_core_tb.sv =====
// lsb_stego_frame_extractor_core_tb: stimulus and verdict for the extractor
// depends on lsfe_pkg, the extractor rtl and lsfe_frame_checker

module lsb_stego_frame_extractor_core_tb import lsfe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // generous bound, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_HEADER_BYTES;
  logic [63:0] wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pixel_byte = '0;
  logic        start_of_image = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic        last;
  logic        flush = 1'b0;
  int          fail_count;
  int          pending;
  int          results_seen;

  // pacing in percent: idle gap chance per sent word, stall chance per receive cycle
  int          send_idle = 15;
  int          recv_idle = 77;

  // what the stimulus believes the registers hold
  int unsigned hdr_cfg  = HEADER_BYTES_RESET;
  logic [63:0] magic_cfg = EXPECTED_MAGIC_RESET;
  int unsigned mlen_cfg = MAGIC_LENGTH_RESET;

  bit          sof_next = 1'b0;   // next word restarts the image
  int          pin_upper = -1;    // -1 random upper bits, 0 all low, 1 all high
  int          payload_words = 0; // words the parser actually consumes
  int          frames = 0;
  int          settings = 1;

  lsb_stego_frame_extractor_core dut (.*);
  lsfe_frame_checker chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stalls at random, one decision per cycle
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // hard stop in case the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still expected", CYCLE_LIMIT, pending);
    $display("Some tests failed");
    $finish;
  end

  // one image word, with an optional idle gap first; returns once accepted
  task automatic push_word(input logic [7:0] px, input logic sof);
    int gap;
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    pixel_byte     <= px;
    start_of_image <= sof;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // one payload bit rides in bit 0 of an image word
  task automatic pay_bit(input logic b);
    logic [6:0] up;
    up = (pin_upper == 0) ? 7'h00 : (pin_upper == 1) ? 7'h7F : 7'($urandom);
    push_word({up, b}, sof_next);
    sof_next = 1'b0;
    payload_words++;
  endtask

  // msb first, as the frame format wants it
  task automatic send_field(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) pay_bit(v[i]);
  endtask

  // the configured number of header bytes; the restart mark goes on the first word sent
  task automatic begin_image();
    logic [7:0] px;
    sof_next = 1'b1;
    for (int i = 0; i < hdr_cfg; i++) begin
      px = (pin_upper == 0) ? 8'h00 : (pin_upper == 1) ? 8'hFF : 8'($urandom);
      push_word(px, sof_next);
      sof_next = 1'b0;
      payload_words++;
    end
  endtask

  // magic bytes as configured, with a flip mask to corrupt chosen ones
  task automatic send_magic(input int n, input logic [63:0] flip);
    logic [63:0] chars;
    chars = magic_cfg ^ flip;
    for (int i = 0; i < n; i++) send_field({24'd0, chars[8*i +: 8]}, 8);
  endtask

  // magic length the block will accept: values above eight count as eight
  function automatic int unsigned magic_span();
    return (mlen_cfg > 8) ? 8 : mlen_cfg;
  endfunction

  // a frame that parses cleanly; the data length field may be zero or negative
  task automatic good_frame(input int nx, input logic [31:0] dlen, input int nd,
                            input bit hold);
    begin_image();
    send_field(magic_span(), 32);
    send_magic(magic_span(), '0);
    send_field(nx, 32);
    repeat (nx) send_field($urandom, 8);
    // pause the sender with extension bytes still in flight
    if (hold) hold_until_drained();
    send_field(dlen, 32);
    repeat (nd) send_field($urandom, 8);
    frames++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // block is idle: nothing expected and the bit queue had time to empty
  task automatic settle();
    hold_until_drained();
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [7:0] hb, input logic [63:0] mg, input logic [3:0] ml);
    settle();
    wr_en    <= 1'b1;
    wr_index <= REG_HEADER_BYTES;
    wr_data  <= {56'd0, hb};
    @(posedge clk);
    wr_index <= REG_EXPECTED_MAGIC;
    wr_data  <= mg;
    @(posedge clk);
    wr_index <= REG_MAGIC_LENGTH;
    wr_data  <= {60'd0, ml};
    @(posedge clk);
    wr_en    <= 1'b0;
    hdr_cfg   = hb;
    magic_cfg = mg;
    mlen_cfg  = ml;
    settings++;
  endtask

  // mostly well formed frames with random content, the rest broken or noise
  task automatic random_frame();
    int unsigned pick, span, n;
    logic [31:0] v;
    pick = $urandom_range(99);
    span = magic_span();
    if (pick < 65) begin
      n = $urandom_range(9);
      if (n < 8) good_frame($urandom_range(1, 4), n % 5 + 1, n % 5 + 1, $urandom_range(19) == 0);
      else if (n == 8) good_frame($urandom_range(1, 4), 32'd0, 0, 1'b0);
      else good_frame($urandom_range(1, 4), 32'h8000_0000 | $urandom, 0, 1'b0);
    end else if (pick < 72) begin
      // negative magic length
      begin_image();
      send_field(32'h8000_0000 | $urandom, 32);
    end else if (pick < 79) begin
      // magic length that differs from the configured one
      v = ($urandom_range(1) == 0) ? $urandom_range(15) : ($urandom & 32'h7FFF_FFFF);
      if (v == span) v = span + 1;
      begin_image();
      send_field(v, 32);
    end else if (pick < 85 && span > 0) begin
      // right length, one magic character wrong
      n = $urandom_range(span - 1);
      begin_image();
      send_field(span, 32);
      send_magic(span, 64'($urandom_range(1, 255)) << (8 * n));
    end else if (pick < 92) begin
      // extension length zero or negative
      begin_image();
      send_field(span, 32);
      send_magic(span, '0);
      send_field(($urandom_range(1) == 0) ? 32'd0 : (32'h8000_0000 | $urandom), 32);
    end else if (pick < 97) begin
      // cut short, the next frame restarts in the middle of a field
      begin_image();
      repeat ($urandom_range(1, 60)) pay_bit($urandom_range(1));
    end else begin
      repeat ($urandom_range(1, 20)) push_word(8'($urandom), 1'b0);
    end
    // a few words past the end of the frame, normally ignored
    repeat ($urandom_range(2)) push_word(8'($urandom), 1'b0);
    frames++;
  endtask

  initial begin
    int base_words, rw;
    logic [63:0] mg;
    int unsigned r;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----

    // reset register values: 54 header bytes, two zero magic characters
    good_frame(1, 32'd2, 2, 1'b0);

    // no header, all-ones magic, length register above eight counts as eight
    write_cfg(8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15);
    pin_upper = 0;
    // most negative magic length, then ignored words after the failure
    begin_image();
    send_field(32'h8000_0000, 32);
    repeat (3) push_word(8'hFF, 1'b0);
    pin_upper = 1;
    // magic length equal to the register but not to the effective length
    begin_image();
    send_field(32'd15, 32);
    pin_upper = -1;
    frames += 2;

    // three header bytes, magic length zero so no magic bytes at all
    write_cfg(8'd3, 64'h0123_4567_89AB_CDEF, 4'd0);
    pin_upper = 0;
    begin_image();
    pin_upper = -1;
    // restart in the middle of the extension length field
    send_field(32'd0, 32);
    send_field(32'd1, 10);
    // restart while still in the header, sender waits for the output
    push_word(8'h5A, 1'b1);
    push_word(8'hA5, 1'b0);
    good_frame(1, 32'd1, 1, 1'b1);
    frames += 2;

    // ---- random part ----
    base_words = payload_words;
    rw = 0;
    while (rw < 480) begin
      if (rw < 160) begin
        send_idle = 15;
        recv_idle = 77;
      end else if (rw < 320) begin
        send_idle = 77;
        recv_idle = 15;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (frames % 4 == 0) begin
        r = $urandom_range(9);
        mg = (r == 0) ? 64'd0 : (r == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
        r = $urandom_range(19);
        write_cfg(($urandom_range(4) == 0) ? 8'($urandom_range(7, 40))
                                           : 8'($urandom_range(6)),
                  mg,
                  (r < 14) ? 4'($urandom_range(1, 8)) :
                  (r < 17) ? 4'd0 : 4'($urandom_range(9, 15)));
      end
      random_frame();
      rw = payload_words - base_words;
    end

    // ---- wind down ----
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    flush <= 1'b1;
    repeat (2) @(posedge clk);

    $display("run covered %0d parsed image words in %0d frames under %0d register settings",
             payload_words, frames, settings);
    $display("%0d result words compared, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
